[rtl/rlfe_pkg.sv]
// ----------------------------------------------------------------------------
// rlfe_pkg: shared definitions for the RGBI linear fade engine
// Widths, saturation limits, divider sizing and the lane control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rlfe_pkg;

    localparam int LEVEL_W  = 16;   // intensity / color level
    localparam int TICK_W   = 13;   // elapsed and total tick counters
    localparam int RAMP_W   = 8;    // ramp time field
    localparam int UNIT_W   = 8;    // ticks per ramp unit
    localparam int NUM_CH   = 4;    // lane 0 intensity, lanes 1..3 red, green, blue

    localparam int TICKS_PER_RAMP_UNIT_DEF = 20;
    localparam int TOTAL_MAX   = 8190;
    localparam int ELAPSED_MAX = 8191;

    // span * remaining ticks, padded to an even width for a radix-4 divider
    localparam int PROD_W    = LEVEL_W + TICK_W;
    localparam int DVD_W     = PROD_W + (PROD_W % 2);
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;     // capture origin and target, form the span
        logic mul;      // span * remaining ticks into the dividend
        logic step;     // two quotient bits
    } t_lane_ctl;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

`default_nettype wire

[rtl/rgbi_linear_fade_engine.sv]
// ----------------------------------------------------------------------------
// rgbi_linear_fade_engine: linear fade of intensity and RGB toward targets
//
// Input channel (i_in_valid / o_in_stall): one transaction per millisecond
// tick with targets, ramp time and the new-command flag. Output channel
// (o_out_valid / i_out_stall): one transaction per input with the four
// levels and the fading flag.
// Four lanes run side by side, each with its own multiplier and a radix-4
// divider; a merge stage applies the window and the blank-start color rule.
// The result is registered after the multiply state, 15 divider steps and the
// merge state, which waits while the output register is full and stalled. The
// input is stalled while a tick is in the lanes, so a new tick is taken only
// once the last one has left the merge state.
// A finished result sits in the output register; the engine accepts and
// works the next tick meanwhile and holds in the merge cycle only while that
// register is still full and stalled.
// Reset (synchronous, active low) clears levels, origins, counters and the
// fade flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbi_linear_fade_engine
    import rlfe_pkg::*;
#(
    parameter logic [UNIT_W-1:0] TICKS_PER_RAMP_UNIT = UNIT_W'(TICKS_PER_RAMP_UNIT_DEF)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_new_command,
    input  wire logic [RAMP_W-1:0]   i_ramp_time,
    input  wire logic [LEVEL_W-1:0]  i_target_intensity,
    input  wire logic [LEVEL_W-1:0]  i_target_r,
    input  wire logic [LEVEL_W-1:0]  i_target_g,
    input  wire logic [LEVEL_W-1:0]  i_target_b,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [LEVEL_W-1:0]  o_out_intensity,
    output logic      [LEVEL_W-1:0]  o_out_r,
    output logic      [LEVEL_W-1:0]  o_out_g,
    output logic      [LEVEL_W-1:0]  o_out_b,
    output logic                     o_fading
);

    localparam int RP_W = RAMP_W + UNIT_W;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step;

    logic [NUM_CH-1:0][LEVEL_W-1:0] r_last;
    logic [NUM_CH-1:0][LEVEL_W-1:0] r_origin;
    logic [TICK_W-1:0] r_total, r_elapsed, r_remain;
    logic              r_fade;
    logic              r_cmd, r_interp;

    logic              r_out_valid;
    logic [NUM_CH-1:0][LEVEL_W-1:0] r_out_level;
    logic              r_out_fading;

    logic              in_accept, commit;
    logic [RP_W-1:0]   ramp_prod;
    logic [TICK_W-1:0] t_eff, e_eff;
    logic              fa_eff, interp_eff;
    t_lane_ctl         lane_ctl;

    logic [NUM_CH-1:0][LEVEL_W-1:0] lane_origin, lane_target, lane_level, lane_tgt_q;
    logic [NUM_CH-1:0][LEVEL_W-1:0] mrg_level, mrg_origin;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign commit     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // tick bookkeeping, resolved at the input transaction
    always_comb begin
        ramp_prod  = RP_W'(i_ramp_time) * RP_W'(TICKS_PER_RAMP_UNIT);
        if (i_new_command) begin
            t_eff = (ramp_prod > RP_W'(TOTAL_MAX)) ? TICK_W'(TOTAL_MAX)
                                                   : ramp_prod[TICK_W-1:0];
            e_eff = '0;
        end else begin
            t_eff = r_total;
            e_eff = r_elapsed;
        end
        fa_eff     = (i_new_command || r_fade) && !(e_eff > t_eff) && (t_eff != '0);
        interp_eff = fa_eff && (e_eff < t_eff);
    end

    assign lane_target[0] = i_target_intensity;
    assign lane_target[1] = i_target_r;
    assign lane_target[2] = i_target_g;
    assign lane_target[3] = i_target_b;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            lane_origin[ch] = i_new_command ? r_last[ch] : r_origin[ch];
        end
    end

    assign lane_ctl.load = in_accept;
    assign lane_ctl.mul  = (r_state == S_MUL);
    assign lane_ctl.step = (r_state == S_DIV);

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        rlfe_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_origin (lane_origin[ch]),
            .i_target (lane_target[ch]),
            .i_remain (r_remain),
            .i_total  (r_total),
            .o_level  (lane_level[ch]),
            .o_target (lane_tgt_q[ch])
        );
    end

    rlfe_merge u_merge (
        .i_interp      (r_interp),
        .i_cmd         (r_cmd),
        .i_lane_level  (lane_level),
        .i_lane_target (lane_tgt_q),
        .i_last        (r_last),
        .o_level       (mrg_level),
        .o_origin      (mrg_origin)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_accept) n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = S_DONE;
            S_DONE: if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_last      <= '0;
            r_origin    <= '0;
            r_total     <= '0;
            r_elapsed   <= '0;
            r_fade      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == S_DIV) ? r_step + 1'b1 : '0;

            if (in_accept) begin
                r_total   <= t_eff;
                r_fade    <= fa_eff;
                r_elapsed <= (e_eff == TICK_W'(ELAPSED_MAX)) ? e_eff : e_eff + 1'b1;
                if (i_new_command) r_origin[0] <= r_last[0];
            end

            if (commit) begin
                r_last <= mrg_level;
                if (r_cmd) begin
                    for (int ch = 1; ch < NUM_CH; ch++) r_origin[ch] <= mrg_origin[ch];
                end
            end

            if (commit)           r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd    <= i_new_command;
            r_interp <= interp_eff;
            r_remain <= t_eff - e_eff;
        end
        if (commit) begin
            r_out_level  <= mrg_level;
            r_out_fading <= r_fade;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_intensity = r_out_level[0];
    assign o_out_r         = r_out_level[1];
    assign o_out_g         = r_out_level[2];
    assign o_out_b         = r_out_level[3];
    assign o_fading        = r_out_fading;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_MUL))
        else $error("input transaction did not start the lanes");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_step == STEP_W'(DIV_STEPS - 1)) |=> (r_state == S_DONE))
        else $error("divider did not finish after its step count");

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && i_out_stall |=> (r_state == S_DONE))
        else $error("result overwrote a stalled output");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && (r_state != S_DONE) |=> !o_out_valid)
        else $error("output transaction repeated");

endmodule

`default_nettype wire

[rtl/rlfe_lane.sv]
// ----------------------------------------------------------------------------
// rlfe_lane: one channel of the fade interpolator
// Computes target +/- |origin - target| * remain / total with a multiply
// cycle followed by a radix-4 restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rlfe_lane
    import rlfe_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_lane_ctl           i_ctl,
    input  wire logic [LEVEL_W-1:0]  i_origin,
    input  wire logic [LEVEL_W-1:0]  i_target,
    input  wire logic [TICK_W-1:0]   i_remain,
    input  wire logic [TICK_W-1:0]   i_total,
    output logic      [LEVEL_W-1:0]  o_level,
    output logic      [LEVEL_W-1:0]  o_target
);

    logic [LEVEL_W-1:0] r_span;
    logic               r_up;
    logic [LEVEL_W-1:0] r_tgt;
    logic [DVD_W-1:0]   r_dvd;
    logic [TICK_W-1:0]  r_rem;
    logic [LEVEL_W-1:0] r_quo;

    logic [TICK_W:0] rem_a, rem_a2, rem_b, rem_b2;
    logic            ge_a, ge_b;

    always_comb begin
        rem_a  = {r_rem, r_dvd[DVD_W-1]};
        ge_a   = (rem_a >= {1'b0, i_total});
        rem_a2 = ge_a ? (rem_a - {1'b0, i_total}) : rem_a;
        rem_b  = {rem_a2[TICK_W-1:0], r_dvd[DVD_W-2]};
        ge_b   = (rem_b >= {1'b0, i_total});
        rem_b2 = ge_b ? (rem_b - {1'b0, i_total}) : rem_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_up   <= (i_origin > i_target);
            r_span <= (i_origin > i_target) ? (i_origin - i_target) : (i_target - i_origin);
            r_tgt  <= i_target;
        end
        if (i_ctl.mul) begin
            r_dvd <= DVD_W'(r_span) * DVD_W'(i_remain);
            r_rem <= '0;
            r_quo <= '0;
        end
        if (i_ctl.step) begin
            r_dvd <= {r_dvd[DVD_W-3:0], 2'b00};
            r_rem <= rem_b2[TICK_W-1:0];
            // quotient never exceeds the span, so leading bits drop harmlessly
            r_quo <= {r_quo[LEVEL_W-3:0], ge_a, ge_b};
        end
    end

    assign o_level  = r_up ? (r_tgt + r_quo) : (r_tgt - r_quo);
    assign o_target = r_tgt;

endmodule

`default_nettype wire

[rtl/rlfe_merge.sv]
// ----------------------------------------------------------------------------
// rlfe_merge: combines lane results into the tick's output levels
// Applies the interpolation window and the blank-start rule for color.
// ----------------------------------------------------------------------------
`default_nettype none

module rlfe_merge
    import rlfe_pkg::*;
(
    input  wire logic                            i_interp,
    input  wire logic                            i_cmd,
    input  wire logic [NUM_CH-1:0][LEVEL_W-1:0]  i_lane_level,
    input  wire logic [NUM_CH-1:0][LEVEL_W-1:0]  i_lane_target,
    input  wire logic [NUM_CH-1:0][LEVEL_W-1:0]  i_last,
    output logic      [NUM_CH-1:0][LEVEL_W-1:0]  o_level,
    output logic      [NUM_CH-1:0][LEVEL_W-1:0]  o_origin
);

    logic blank;

    always_comb begin
        o_level[0]  = i_interp ? i_lane_level[0] : i_lane_target[0];
        o_origin[0] = i_last[0];
        // new command landing on zero intensity: color starts at its target
        blank = i_cmd && (o_level[0] == '0);
        for (int ch = 1; ch < NUM_CH; ch++) begin
            o_level[ch]  = (i_interp && !blank) ? i_lane_level[ch] : i_lane_target[ch];
            o_origin[ch] = blank ? i_lane_target[ch] : i_last[ch];
        end
    end

endmodule

`default_nettype wire
